/* sv/whist_pkg.sv */
// ----------------------------------------------------------------------------
// whist_pkg
// Shared types and constants for the two-dimensional weighted histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package whist_pkg;

  localparam int MAX_BINS_X = 64;
  localparam int MAX_BINS_Y = 64;
  localparam int DEPTH      = MAX_BINS_X * MAX_BINS_Y;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [47:0] CNT_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] CNT_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [48:0] UNIT_WEIGHT = 49'sd65536;

  typedef enum logic [1:0] {
    MODE_ACC   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LOW       = 3'd0,
    CFG_X_SCALE     = 3'd1,
    CFG_Y_LOW       = 3'd2,
    CFG_Y_SCALE     = 3'd3,
    CFG_BINS_X      = 3'd4,
    CFG_BINS_Y      = 3'd5,
    CFG_USE_WEIGHTS = 3'd6,
    CFG_SPARE       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] x_sample;
    logic signed [31:0] y_sample;
    logic signed [31:0] weight;
    logic [5:0]         bin_col;
    logic [5:0]         bin_row;
    logic signed [47:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic               in_range;
    logic [5:0]         out_col;
    logic [5:0]         out_row;
    logic signed [47:0] bin_value;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic diff_en;
    logic mul_en;
    logic addr_en;
    logic rd_en;
    logic wb_en;
  } whist_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } whist_sts_t;

endpackage

`default_nettype wire

/* sv/weighted_histogram_2d.sv */
// ----------------------------------------------------------------------------
// weighted_histogram_2d
// Two-dimensional weighted histogram with a 64 x 64 bin store.
//
// in_valid/in_stall/in_data carry one word: mode, x/y sample, weight, bin
// address and write value. mode 0 accumulates a sample, 1 reads a bin,
// 2 preloads a bin. out_valid/out_stall/out_data return one word per input
// word: range flag, bin address, bin value after the operation, saturation.
// cfg_we/cfg_index/cfg_wdata write the edge, scale, bin count and weight
// registers; write them only while the block is idle.
// One word is in work at a time: a new word is taken only once the last
// has gone through offset, multiply, bin check, store read and write back.
// After reset the bin store is cleared one entry a cycle, all 4096 entries,
// with in_stall high. A stalled result sits in the output register; the
// next word is accepted meanwhile and waits at write back until the
// output register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_histogram_2d (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [whist_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [whist_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire whist_pkg::in_word_t              in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output whist_pkg::out_word_t                  out_data
);
  import whist_pkg::*;

  whist_cmd_t cmd;
  whist_sts_t sts;

  whist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  whist_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

/* sv/whist_ctrl.sv */
// ----------------------------------------------------------------------------
// whist_ctrl
// Sequencer: store clearing after reset, then one word at a time through
// offset, multiply, bin check, store read and write back.
// ----------------------------------------------------------------------------
`default_nettype none

module whist_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire whist_pkg::whist_sts_t sts,
  output whist_pkg::whist_cmd_t     cmd
);
  import whist_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DIFF  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_ADDR  = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_WB    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (!sts.out_busy) begin
          cmd.wb_en = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/whist_dp.sv */
// ----------------------------------------------------------------------------
// whist_dp
// Datapath: configuration registers, bin arithmetic, bin store with its
// clearing counter, saturating accumulate and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module whist_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [whist_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [whist_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire whist_pkg::in_word_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output whist_pkg::out_word_t                     out_data,
  input  wire whist_pkg::whist_cmd_t               cmd,
  output whist_pkg::whist_sts_t                    sts
);
  import whist_pkg::*;

  // configuration
  logic signed [31:0] x_low_r, y_low_r;
  logic [31:0]        x_scale_r, y_scale_r;
  logic [6:0]         bins_x_r, bins_y_r;
  logic               use_weights_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r       <= '0;
      x_scale_r     <= 32'd65536;
      y_low_r       <= '0;
      y_scale_r     <= 32'd65536;
      bins_x_r      <= 7'd64;
      bins_y_r      <= 7'd64;
      use_weights_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_X_LOW:       x_low_r       <= cfg_wdata;
        CFG_X_SCALE:     x_scale_r     <= cfg_wdata;
        CFG_Y_LOW:       y_low_r       <= cfg_wdata;
        CFG_Y_SCALE:     y_scale_r     <= cfg_wdata;
        CFG_BINS_X:      bins_x_r      <= cfg_wdata[6:0];
        CFG_BINS_Y:      bins_y_r      <= cfg_wdata[6:0];
        CFG_USE_WEIGHTS: use_weights_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // item
  in_word_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end

  // offset from low edge, sign and magnitude
  logic signed [32:0] x_diff, y_diff;
  logic               x_neg_r, y_neg_r;
  logic [31:0]        x_mag_r, y_mag_r;

  always_comb begin
    x_diff = 33'(item_r.x_sample) - 33'(x_low_r);
    y_diff = 33'(item_r.y_sample) - 33'(y_low_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      x_neg_r <= x_diff[32];
      y_neg_r <= y_diff[32];
      x_mag_r <= x_diff[32] ? 32'(-x_diff) : x_diff[31:0];
      y_mag_r <= y_diff[32] ? 32'(-y_diff) : y_diff[31:0];
    end
  end

  // scale products
  logic [63:0] x_prod_r, y_prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      x_prod_r <= 64'(x_mag_r) * 64'(x_scale_r);
      y_prod_r <= 64'(y_mag_r) * 64'(y_scale_r);
    end
  end

  // bin check and address
  logic [31:0]       x_q, y_q, nbx, nby;
  logic              x_ok, y_ok, hit;
  logic [5:0]        col, row;
  logic              hit_r;
  logic [5:0]        col_r, row_r;
  logic [ADDR_W-1:0] addr_r;

  always_comb begin
    x_q  = x_prod_r[63:32];
    y_q  = y_prod_r[63:32];
    nbx  = (32'(bins_x_r) < 32'(MAX_BINS_X)) ? 32'(bins_x_r) : 32'(MAX_BINS_X);
    nby  = (32'(bins_y_r) < 32'(MAX_BINS_Y)) ? 32'(bins_y_r) : 32'(MAX_BINS_Y);
    x_ok = (nbx != '0) && (x_neg_r ? (x_q == '0) : (x_q < nbx));
    y_ok = (nby != '0) && (y_neg_r ? (y_q == '0) : (y_q < nby));
    col  = '0;
    row  = '0;
    hit  = 1'b0;
    unique case (item_r.mode)
      MODE_ACC: begin
        hit = x_ok && y_ok;
        if (hit) begin
          col = x_neg_r ? 6'd0 : x_q[5:0];
          row = y_neg_r ? 6'd0 : y_q[5:0];
        end
      end
      MODE_READ, MODE_WRITE: begin
        hit = (11'(item_r.bin_col) < 11'(MAX_BINS_X)) &&
              (11'(item_r.bin_row) < 11'(MAX_BINS_Y));
        if (hit) begin
          col = item_r.bin_col;
          row = item_r.bin_row;
        end
      end
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      hit_r  <= hit;
      col_r  <= col;
      row_r  <= row;
      addr_r <= ADDR_W'(row) * ADDR_W'(MAX_BINS_X) + ADDR_W'(col);
    end
  end

  // bin store
  logic [47:0]       mem [DEPTH];
  logic [47:0]       rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              clr_done_r;
  logic              wr_en;
  logic [47:0]       wr_data;

  assign sts.clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (sts.clr_last) clr_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data_r <= mem[addr_r];
  end

  // saturating accumulate and result
  logic signed [48:0] w_ext, sum;
  logic               sum_ovf;
  logic signed [47:0] sum_clip;
  out_word_t          res;

  always_comb begin
    w_ext    = use_weights_r ? 49'(item_r.weight) : UNIT_WEIGHT;
    sum      = 49'($signed(rd_data_r)) + w_ext;
    sum_ovf  = sum[48] ^ sum[47];
    sum_clip = sum_ovf ? (sum[48] ? CNT_MIN : CNT_MAX) : sum[47:0];
    res      = '0;
    wr_en    = 1'b0;
    wr_data  = sum_clip;
    if (hit_r) begin
      res.in_range = 1'b1;
      res.out_col  = col_r;
      res.out_row  = row_r;
      unique case (item_r.mode)
        MODE_ACC: begin
          res.bin_value = sum_clip;
          res.saturated = sum_ovf;
          wr_en         = cmd.wb_en;
        end
        MODE_READ: begin
          res.bin_value = rd_data_r;
        end
        MODE_WRITE: begin
          res.bin_value = item_r.write_value;
          wr_data       = item_r.write_value;
          wr_en         = cmd.wb_en;
        end
        default: res = '0;
      endcase
    end
  end

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.wb_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb_en) out_r <= res;
  end

  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

`ifndef SYNTHESIS
  a_wb_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb_en |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_no_load_before_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> clr_done_r)
    else $error("word taken before store clear finished");

  a_sat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.saturated) |-> out_r.in_range)
    else $error("saturation flagged on a miss");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.in_range) |->
      (out_r.bin_value == '0 && out_r.out_col == '0 && out_r.out_row == '0))
    else $error("miss result not zero");

  a_wb_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> !cmd.load)
    else $error("new word taken during write back");
`endif

endmodule

`default_nettype wire

/* tb/weighted_histogram_2d_test.sv */
// ----------------------------------------------------------------------------
// weighted_histogram_2d_test
// Self-checking bench for the two-dimensional weighted histogram. Words are
// queued by phase, each phase under its own edge, scale, bin count and weight
// settings. Every accepted word runs through a bin store mirror, which yields
// the result expected back, and results are compared field by field. Both
// channels idle and stall at random. Directed words cover the edges of the
// range, saturation at both count limits and the unused mode.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_histogram_2d_test;
  import whist_pkg::*;

  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int RANDOM_PHASES   = 6;
  localparam int WORDS_PER_PHASE = 110;
  localparam int PRINT_LIMIT     = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;

  // mirror of the settings and the bin store
  logic signed [31:0] x_lo_r, y_lo_r;
  logic [31:0]        x_sc_r, y_sc_r;
  logic [6:0]         nbins_x_r, nbins_y_r;
  logic               weights_on_r;
  logic signed [47:0] bin_store [DEPTH];

  in_word_t  pending_words [$];
  out_word_t expected_bins [$];

  int queued_words = 0;
  int sent_words = 0;
  int checked_words = 0;
  int mismatches = 0;
  int hits = 0;
  int clips = 0;
  int phases = 0;
  int in_wait = 0;
  int out_wait = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  weighted_histogram_2d uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // bin of one axis: offset times scale, truncated toward zero
  function automatic logic locate_bin(input logic [31:0] v, input logic [31:0] lo,
                                      input logic [31:0] sc, input logic [6:0] nb,
                                      output logic [5:0] idx);
    logic [32:0] d;
    logic [32:0] mag;
    logic [64:0] prod;
    logic [32:0] q;
    logic [6:0]  lim;
    d    = {v[31], v} - {lo[31], lo};
    mag  = d[32] ? -d : d;
    prod = {32'b0, mag} * {33'b0, sc};
    q    = prod[64:32];
    lim  = (nb > 7'(MAX_BINS_X)) ? 7'(MAX_BINS_X) : nb;
    idx  = 6'd0;
    if (lim == 7'd0) return 1'b0;
    if (d[32]) return q == 33'd0;
    if (q >= {26'b0, lim}) return 1'b0;
    idx = q[5:0];
    return 1'b1;
  endfunction

  function automatic out_word_t predict_bin_update(input in_word_t w);
    out_word_t          r;
    logic [5:0]         cx;
    logic [5:0]         ry;
    logic               ok_x;
    logic               ok_y;
    logic signed [47:0] wt;
    logic signed [47:0] cur;
    logic [48:0]        sum;
    r = '0;
    case (w.mode)
      MODE_ACC: begin
        ok_x = locate_bin(w.x_sample, x_lo_r, x_sc_r, nbins_x_r, cx);
        ok_y = locate_bin(w.y_sample, y_lo_r, y_sc_r, nbins_y_r, ry);
        if (ok_x && ok_y) begin
          wt  = weights_on_r ? {{16{w.weight[31]}}, w.weight} : 48'sd65536;
          cur = bin_store[{ry, cx}];
          sum = {cur[47], cur} + {wt[47], wt};
          if (sum[48] != sum[47]) begin
            sum = sum[48] ? {1'b1, CNT_MIN} : {1'b0, CNT_MAX};
            r.saturated = 1'b1;
          end
          bin_store[{ry, cx}] = sum[47:0];
          r.in_range  = 1'b1;
          r.out_col   = cx;
          r.out_row   = ry;
          r.bin_value = sum[47:0];
        end
      end
      MODE_READ, MODE_WRITE: begin
        if (w.mode == MODE_WRITE) bin_store[{w.bin_row, w.bin_col}] = w.write_value;
        r.in_range  = 1'b1;
        r.out_col   = w.bin_col;
        r.out_row   = w.bin_row;
        r.bin_value = bin_store[{w.bin_row, w.bin_col}];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_word_t compose_word(input mode_t m, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] wt,
                                            input logic [5:0] c, input logic [5:0] r,
                                            input logic [47:0] wv);
    in_word_t w;
    w.mode        = m;
    w.x_sample    = x;
    w.y_sample    = y;
    w.weight      = wt;
    w.bin_col     = c;
    w.bin_row     = r;
    w.write_value = wv;
    return w;
  endfunction

  // mostly inside the bins in use, some just under the low edge, some anywhere
  function automatic logic [31:0] coord_near_bins(input logic [31:0] lo,
                                                  input logic [31:0] sc,
                                                  input logic [6:0] nb);
    longint unsigned span;
    logic [63:0]     d;
    int              sel;
    sel = $urandom_range(0, 9);
    if (sel < 7 && sc != 0 && nb != 0) begin
      span = ({57'b0, (nb > 7'(MAX_BINS_X)) ? 7'(MAX_BINS_X) : nb} << 32) / {32'b0, sc};
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      d = {$urandom, $urandom};
      d = d % span;
      return lo + d[31:0];
    end
    if (sel < 8) return lo - $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    logic [63:0] r64;
    int          pick;
    int          tx;
    int          ty;
    r64           = {$urandom, $urandom};
    w.mode        = MODE_ACC;
    w.x_sample    = $urandom;
    w.y_sample    = $urandom;
    w.weight      = $urandom;
    w.bin_col     = 6'($urandom);
    w.bin_row     = 6'($urandom);
    w.write_value = r64[47:0];
    tx   = (nbins_x_r == 0 || nbins_x_r > 64) ? 64 : int'(nbins_x_r);
    ty   = (nbins_y_r == 0 || nbins_y_r > 64) ? 64 : int'(nbins_y_r);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      w.x_sample = coord_near_bins(x_lo_r, x_sc_r, nbins_x_r);
      w.y_sample = coord_near_bins(y_lo_r, y_sc_r, nbins_y_r);
    end else if (pick < 92) begin
      w.mode = (pick < 80) ? MODE_READ : MODE_WRITE;
      if ($urandom_range(0, 3) != 0) begin
        w.bin_col = 6'($urandom_range(0, tx - 1));
        w.bin_row = 6'($urandom_range(0, ty - 1));
      end
      if (w.mode == MODE_WRITE && $urandom_range(0, 1)) begin
        if ($urandom_range(0, 1)) w.write_value = CNT_MAX - 48'($urandom_range(0, 32'h3_0000));
        else w.write_value = CNT_MIN + 48'($urandom_range(0, 32'h3_0000));
      end
    end else if (pick < 96) begin
      w.mode = MODE_NONE;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at result %0d, %s: got %h, expected %h",
               checked_words, what, got, want);
    mismatches++;
  endtask

  task automatic queue_word(input in_word_t w);
    pending_words.push_back(w);
    queued_words++;
  endtask

  task automatic drain();
    while (checked_words < queued_words) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_X_LOW:       x_lo_r = val;
      CFG_X_SCALE:     x_sc_r = val;
      CFG_Y_LOW:       y_lo_r = val;
      CFG_Y_SCALE:     y_sc_r = val;
      CFG_BINS_X:      nbins_x_r = val[6:0];
      CFG_BINS_Y:      nbins_y_r = val[6:0];
      CFG_USE_WEIGHTS: weights_on_r = val[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] xlo, input logic [31:0] xsc,
                               input logic [31:0] ylo, input logic [31:0] ysc,
                               input logic [6:0] bx, input logic [6:0] by,
                               input logic wts);
    write_reg(CFG_X_LOW, xlo);
    write_reg(CFG_X_SCALE, xsc);
    write_reg(CFG_Y_LOW, ylo);
    write_reg(CFG_Y_SCALE, ysc);
    write_reg(CFG_BINS_X, {25'b0, bx});
    write_reg(CFG_BINS_Y, {25'b0, by});
    write_reg(CFG_USE_WEIGHTS, {31'b0, wts});
    @(posedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  // input side
  always @(posedge clk) begin : drive_words
    logic holding;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_wait = 0;
    end else begin
      holding = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        expected_bins.push_back(predict_bin_update(in_data));
        sent_words++;
        in_wait = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (!holding) begin
        if (in_wait > 0 || pending_words.size() == 0) begin
          if (in_wait > 0) in_wait--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_words++;
        if (expected_bins.size() == 0) begin
          report_mismatch("result with nothing pending", out_data.bin_value, '0);
        end else begin
          want = expected_bins.pop_front();
          if (out_data.in_range !== want.in_range)
            report_mismatch("in_range", 48'(out_data.in_range), 48'(want.in_range));
          if (out_data.out_col !== want.out_col)
            report_mismatch("out_col", 48'(out_data.out_col), 48'(want.out_col));
          if (out_data.out_row !== want.out_row)
            report_mismatch("out_row", 48'(out_data.out_row), 48'(want.out_row));
          if (out_data.bin_value !== want.bin_value)
            report_mismatch("bin_value", out_data.bin_value, want.bin_value);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", 48'(out_data.saturated), 48'(want.saturated));
          hits  += int'(want.in_range);
          clips += int'(want.saturated);
        end
        out_wait = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("weighted_histogram_2d_test: done, errors");
      $finish;
    end
  end

  initial begin : run
    logic [31:0] xlo;
    logic [31:0] xsc;
    logic [31:0] ylo;
    logic [31:0] ysc;
    logic [6:0]  bx;
    logic [6:0]  by;
    x_lo_r       = '0;
    x_sc_r       = 32'h0001_0000;
    y_lo_r       = '0;
    y_sc_r       = 32'h0001_0000;
    nbins_x_r    = 7'd64;
    nbins_y_r    = 7'd64;
    weights_on_r = 1'b0;
    foreach (bin_store[i]) bin_store[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one bin per unit from zero, unit weight
    queue_word(compose_word(MODE_ACC, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
                            6'd63, 6'd63, '1));
    queue_word(compose_word(MODE_ACC, 32'h003F_FFFF, 32'h003F_0000, 32'h8000_0000,
                            6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_ACC, 32'h0040_0000, 32'h0000_8000, '0, 6'd1, 6'd1, '0));
    queue_word(compose_word(MODE_ACC, 32'hFFFF_FFFF, 32'h0000_0001, '0, 6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_ACC, 32'hFFFF_0000, 32'h0000_0000, '0, 6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_ACC, 32'h7FFF_FFFF, 32'h8000_0000, '0, 6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_READ, '0, '0, '0, 6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_WRITE, '0, '0, '0, 6'd5, 6'd7, CNT_MAX - 48'sh8000));
    queue_word(compose_word(MODE_ACC, 32'h0005_8000, 32'h0007_4000, '0, 6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_WRITE, '0, '0, '0, 6'd63, 6'd63, CNT_MIN));
    queue_word(compose_word(MODE_READ, '0, '0, '0, 6'd63, 6'd63, '0));
    queue_word(compose_word(MODE_WRITE, '0, '0, '0, 6'd0, 6'd63, '1));
    queue_word(compose_word(MODE_NONE, '1, '1, '1, 6'd63, 6'd63, '1));
    queue_word(compose_word(MODE_READ, '0, '0, '0, 6'd63, 6'd0, '0));
    drain();

    // x from -1.0 at four bins per unit, weights on
    load_settings(32'hFFFF_0000, 32'h0004_0000, 32'h0000_0000, 32'h0001_0000,
                  7'd64, 7'd64, 1'b1);
    queue_word(compose_word(MODE_WRITE, '0, '0, '0, 6'd2, 6'd3, CNT_MIN + 48'sd5));
    queue_word(compose_word(MODE_ACC, 32'hFFFF_8000, 32'h0003_0000, 32'h8000_0000,
                            6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_ACC, 32'hFFFF_0000, 32'h0000_0000, 32'h7FFF_FFFF,
                            6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_ACC, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000,
                            6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_ACC, 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                            6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_WRITE, '0, '0, '0, 6'd10, 6'd10, CNT_MAX));
    queue_word(compose_word(MODE_ACC, 32'h0001_8000, 32'h000A_0000, 32'h7FFF_FFFF,
                            6'd0, 6'd0, '0));
    queue_word(compose_word(MODE_READ, '0, '0, '0, 6'd10, 6'd10, '0));
    drain();

    // no x bins at all
    load_settings(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000,
                  7'd0, 7'd64, 1'b0);
    repeat (6) queue_word(random_word());
    drain();

    // extreme edges and scales, bin counts above the store size
    load_settings(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                  7'd127, 7'd127, 1'b1);
    repeat (40) queue_word(random_word());
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      xlo = ($urandom_range(0, 3) == 0) ? $urandom
                                        : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      ylo = ($urandom_range(0, 3) == 0) ? $urandom
                                        : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      case ($urandom_range(0, 2))
        0:       xsc = 32'h0001_0000;
        1:       xsc = $urandom_range(32'h1000, 32'h40_0000);
        default: xsc = $urandom;
      endcase
      case ($urandom_range(0, 2))
        0:       ysc = 32'h0001_0000;
        1:       ysc = $urandom_range(32'h1000, 32'h40_0000);
        default: ysc = $urandom;
      endcase
      bx = 7'($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 64));
      by = 7'($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 64));
      load_settings(xlo, xsc, ylo, ysc, bx, by, 1'($urandom_range(0, 1)));
      no_idle = (p == 2);
      for (int i = 0; i < WORDS_PER_PHASE; i++) queue_word(random_word());
      drain();
      no_idle = 1'b0;
    end

    repeat (12) @(posedge clk);
    if (expected_bins.size() != 0)
      report_mismatch("results never returned", 48'(expected_bins.size()), '0);
    $display("summary: %0d words over %0d setting phases, %0d results checked",
             sent_words, phases + 1, checked_words);
    $display("summary: %0d landed in a bin or addressed one, %0d clipped, %0d mismatches",
             hits, clips, mismatches);
    if (mismatches == 0) begin
      $display("weighted_histogram_2d_test: done, clean");
    end else begin
      $display("weighted_histogram_2d_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
